/* sv/smm_pkg.sv */
package smm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = 6;
    localparam int IDX_W       = 6;
    localparam int POS_W       = 3;
    localparam int DIM_W       = 4;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = PROD_W + 3;

    typedef enum logic [1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_MUL    = 2'd0,
        MODE_MUL_BT = 2'd1,
        MODE_VEC    = 2'd2,
        MODE_XPOSE  = 2'd3
    } mode_t;

    localparam logic CFG_DIMENSION = 1'b0;
    localparam logic CFG_MODE      = 1'b1;

    // tag that travels with each operand pair through the MAC
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic xpose;
    } mac_tag_t;

endpackage

/* sv/smm_mac.sv */
module smm_mac import smm_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_tag_t                 tag_i,
    input  logic signed [DATA_W-1:0] a_i,
    input  logic signed [DATA_W-1:0] b_i,
    output logic                     done_o,
    output logic        [DATA_W-1:0] value_o,
    output logic                     sat_o
);

    mac_tag_t                  mul_tag_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      done_reg;
    logic signed [ACC_W-1:0]   shifted;
    logic [ACC_W-DATA_W:0]     high_bits;
    logic                      in_range;

    // transpose passes the element through, pre-scaled so the final shift undoes it
    always_comb begin
        if (tag_i.xpose) begin
            prod_next = PROD_W'(a_i) <<< FRAC_BITS;
        end else begin
            prod_next = a_i * b_i;
        end
    end

    always_comb begin
        if (mul_tag_reg.first) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_tag_reg <= '0;
            done_reg    <= 1'b0;
        end else begin
            mul_tag_reg <= tag_i;
            done_reg    <= mul_tag_reg.vld && mul_tag_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_i.vld) begin
            prod_reg <= prod_next;
        end
        if (mul_tag_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    // floor shift, then clip to 32 bits
    assign shifted   = acc_reg >>> FRAC_BITS;
    assign high_bits = shifted[ACC_W-1:DATA_W-1];
    assign in_range  = (&high_bits) || !(|high_bits);

    always_comb begin
        if (in_range) begin
            value_o = shifted[DATA_W-1:0];
        end else if (shifted[ACC_W-1]) begin
            value_o = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            value_o = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign sat_o  = !in_range;
    assign done_o = done_reg;

endmodule

/* sv/square_matrix_multiply_engine.sv */
// Square matrix engine for signed Q16.16 data. Words on the s_ channel either
// load one element of store A or B (row-major index, one word per cycle) or
// start a compute run; loads and action 3 produce nothing. A compute run emits
// the result matrix row-major on the m_ channel, last word flagged, for the
// mode in the operation_mode register: A*B, A*B^T, A times the vector in B[0..d-1]
// (column reported as 0), or A^T. Sums of products are kept exact, floor-shifted
// right by 16 and clipped to 32 bits; saturated marks a clipped word. A dimension
// of 0 acts as 1 and above 8 as 8. Each result word of a compute run is built
// by one read of each store per term into a single multiply-accumulate, then
// the read, multiply and accumulate registers and an emit step; m_ready can
// stall the emit. s_ready is low for the whole run. Configuration writes go through
// cfg_ and are taken every cycle; write them only while no run is in progress.
module square_matrix_multiply_engine import smm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // input words
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [IDX_W-1:0]  s_element_index,
    input  logic [DATA_W-1:0] s_element_value,
    // result words
    output logic              m_valid,
    input  logic              m_ready,
    output logic [POS_W-1:0]  m_result_row,
    output logic [POS_W-1:0]  m_result_column,
    output logic [DATA_W-1:0] m_result_value,
    output logic              m_saturated,
    output logic              m_last_result,
    // register writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [DIM_W-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t             st_reg, st_next;

    // configuration registers
    logic [DIM_W-1:0]   dim_reg;
    logic [1:0]         mode_reg;

    // per-run copies, dimension already clamped
    logic [DIM_W-1:0]   run_dim_reg;
    mode_t              run_mode_reg;
    logic [DIM_W-1:0]   dim_clamped;

    // loop counters: row, column, term
    logic [POS_W-1:0]   i_reg, i_next;
    logic [POS_W-1:0]   j_reg, j_next;
    logic [POS_W-1:0]   k_reg, k_next;
    logic [DIM_W-1:0]   terms;
    logic [DIM_W-1:0]   cols;
    logic               k_last;
    logic               j_last;
    logic               i_last;

    // stores
    logic [DATA_W-1:0]  mem_a [STORE_DEPTH];
    logic [DATA_W-1:0]  mem_b [STORE_DEPTH];
    logic [DATA_W-1:0]  rd_a_reg;
    logic [DATA_W-1:0]  rd_b_reg;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;
    logic               s_fire;
    logic               wr_ok;

    mac_tag_t           iss_tag;
    mac_tag_t           rd_tag_reg;

    logic               mac_done;
    logic [DATA_W-1:0]  mac_value;
    logic               mac_sat;

    // output register
    logic               m_valid_reg;
    logic [POS_W-1:0]   m_row_reg;
    logic [POS_W-1:0]   m_col_reg;
    logic [DATA_W-1:0]  m_value_reg;
    logic               m_sat_reg;
    logic               m_last_reg;
    logic               out_load;

    function automatic logic [ADDR_W-1:0] rm_addr(
        input logic [POS_W-1:0] row,
        input logic [POS_W-1:0] col,
        input logic [DIM_W-1:0] d
    );
        logic [ADDR_W:0] sum;
        sum = (ADDR_W+1)'(row) * (ADDR_W+1)'(d) + (ADDR_W+1)'(col);
        return sum[ADDR_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = (st_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign wr_ok     = ({1'b0, s_element_index} < (IDX_W+1)'(STORE_DEPTH));

    always_comb begin
        if (dim_reg == '0) begin
            dim_clamped = DIM_W'(1);
        end else if (dim_reg > DIM_W'(MAX_DIM)) begin
            dim_clamped = DIM_W'(MAX_DIM);
        end else begin
            dim_clamped = dim_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg  <= DIM_W'(3);
            mode_reg <= MODE_MUL;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DIMENSION: dim_reg  <= cfg_data;
                CFG_MODE:      mode_reg <= cfg_data[1:0];
                default:       dim_reg  <= dim_reg;
            endcase
        end
    end

    // one term per word in transpose, d terms otherwise
    assign terms  = (run_mode_reg == MODE_XPOSE) ? DIM_W'(1) : run_dim_reg;
    assign cols   = (run_mode_reg == MODE_VEC) ? DIM_W'(1) : run_dim_reg;
    assign k_last = ({1'b0, k_reg} == terms - DIM_W'(1));
    assign j_last = ({1'b0, j_reg} == cols - DIM_W'(1));
    assign i_last = ({1'b0, i_reg} == run_dim_reg - DIM_W'(1));

    always_comb begin
        case (run_mode_reg)
            MODE_MUL: begin
                addr_a = rm_addr(i_reg, k_reg, run_dim_reg);
                addr_b = rm_addr(k_reg, j_reg, run_dim_reg);
            end
            MODE_MUL_BT: begin
                addr_a = rm_addr(i_reg, k_reg, run_dim_reg);
                addr_b = rm_addr(j_reg, k_reg, run_dim_reg);
            end
            MODE_VEC: begin
                addr_a = rm_addr(i_reg, k_reg, run_dim_reg);
                addr_b = ADDR_W'(k_reg);
            end
            MODE_XPOSE: begin
                addr_a = rm_addr(j_reg, i_reg, run_dim_reg);
                addr_b = '0;
            end
            default: begin
                addr_a = '0;
                addr_b = '0;
            end
        endcase
    end

    always_comb begin
        iss_tag.vld   = (st_reg == ST_ISSUE);
        iss_tag.first = (k_reg == '0);
        iss_tag.last  = k_last;
        iss_tag.xpose = (run_mode_reg == MODE_XPOSE);
    end

    // stores: loads only in idle, read data used only during a run, so no overlap
    always_ff @(posedge aclk) begin
        if (s_fire && wr_ok && s_action == ACT_LOAD_A) begin
            mem_a[s_element_index[ADDR_W-1:0]] <= s_element_value;
        end
        rd_a_reg <= mem_a[addr_a];
    end

    always_ff @(posedge aclk) begin
        if (s_fire && wr_ok && s_action == ACT_LOAD_B) begin
            mem_b[s_element_index[ADDR_W-1:0]] <= s_element_value;
        end
        rd_b_reg <= mem_b[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_tag_reg <= '0;
        end else begin
            rd_tag_reg <= iss_tag;
        end
    end

    smm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tag_i   (rd_tag_reg),
        .a_i     (rd_a_reg),
        .b_i     (rd_b_reg),
        .done_o  (mac_done),
        .value_o (mac_value),
        .sat_o   (mac_sat)
    );

    assign out_load = (st_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        st_next = st_reg;
        i_next  = i_reg;
        j_next  = j_reg;
        k_next  = k_reg;
        case (st_reg)
            ST_IDLE: begin
                if (s_fire && s_action == ACT_COMPUTE) begin
                    st_next = ST_ISSUE;
                    i_next  = '0;
                    j_next  = '0;
                    k_next  = '0;
                end
            end
            ST_ISSUE: begin
                k_next = k_reg + POS_W'(1);
                if (k_last) begin
                    st_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    st_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    k_next = '0;
                    if (i_last && j_last) begin
                        st_next = ST_IDLE;
                    end else begin
                        st_next = ST_ISSUE;
                        if (j_last) begin
                            j_next = '0;
                            i_next = i_reg + POS_W'(1);
                        end else begin
                            j_next = j_reg + POS_W'(1);
                        end
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            i_reg  <= '0;
            j_reg  <= '0;
            k_reg  <= '0;
        end else begin
            st_reg <= st_next;
            i_reg  <= i_next;
            j_reg  <= j_next;
            k_reg  <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_dim_reg  <= DIM_W'(1);
            run_mode_reg <= MODE_MUL;
        end else if (s_fire && s_action == ACT_COMPUTE) begin
            run_dim_reg  <= dim_clamped;
            run_mode_reg <= mode_t'(mode_reg);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_row_reg   <= i_reg;
            m_col_reg   <= j_reg;
            m_value_reg <= mac_value;
            m_sat_reg   <= mac_sat;
            m_last_reg  <= i_last && j_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_result_row    = m_row_reg;
    assign m_result_column = m_col_reg;
    assign m_result_value  = m_value_reg;
    assign m_saturated     = m_sat_reg;
    assign m_last_result   = m_last_reg;

    // the MAC finishes a word only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> st_reg == ST_WAIT)
        else $error("MAC completion outside wait state");

    // a new result word appears only from the emit state
    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(st_reg == ST_EMIT))
        else $error("result word loaded outside emit state");

    // a compute word starts issuing reads in the next cycle
    a_compute_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_action == ACT_COMPUTE |=> st_reg == ST_ISSUE)
        else $error("compute word did not start a run");

    // operands in flight only during a run
    a_read_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_tag_reg.vld |-> (st_reg == ST_ISSUE || st_reg == ST_WAIT))
        else $error("store read data outside a run");

endmodule

/* dv/square_matrix_multiply_engine_tb.sv */
`timescale 1ns / 1ps

module square_matrix_multiply_engine_tb;
    import smm_pkg::*;

    localparam int RESET_CYCLES  = 8;
    localparam int WORD_TARGET   = 470;          // stimulus stops near this many words
    localparam int CALM_AFTER    = 400;          // no idling on either side past this point
    localparam int SETTLE_CYCLES = 2 * MAX_DIM + 8;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int PRINT_CAP     = 100;

    // one element of a result matrix as it should leave the m_ channel
    typedef struct {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  column;
        logic [DATA_W-1:0] value;
        logic              sat;
        logic              last;
    } result_element_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_action;
    logic [IDX_W-1:0]  s_element_index;
    logic [DATA_W-1:0] s_element_value;
    logic              m_valid;
    logic              m_ready;
    logic [POS_W-1:0]  m_result_row;
    logic [POS_W-1:0]  m_result_column;
    logic [DATA_W-1:0] m_result_value;
    logic              m_saturated;
    logic              m_last_result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [DIM_W-1:0]  cfg_data;

    // shadow copy of the block: both stores, which entries hold data, registers
    logic [DATA_W-1:0]      a_mem [STORE_DEPTH];
    logic [DATA_W-1:0]      b_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] a_set;
    logic [STORE_DEPTH-1:0] b_set;
    logic [DIM_W-1:0]       dim_reg;
    mode_t                  mode_reg;

    // result elements predicted but not yet seen on m_, oldest first
    result_element_t owed_elements[$];

    bit idle_on;
    int error_count;
    int words_sent;
    int ignored_words;
    int results_seen;
    int saturated_owed;
    int runs_by_mode [4];
    int cycle_count;

    square_matrix_multiply_engine uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_element_index (s_element_index),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_row    (m_result_row),
        .m_result_column (m_result_column),
        .m_result_value  (m_result_value),
        .m_saturated     (m_saturated),
        .m_last_result   (m_last_result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d elements still owed",
                     cycle_count, owed_elements.size());
            $display("square_matrix_multiply_engine_tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // clamp of the dimension register: 0 acts as 1, anything above MAX_DIM as MAX_DIM
    function automatic int effective_dim();
        if (dim_reg == 0)
            return 1;
        if (dim_reg > MAX_DIM)
            return MAX_DIM;
        return int'(dim_reg);
    endfunction

    // Exact Q16.16 dot product over the shadow stores: full-width sum, floor
    // shift by FRAC_BITS, then clip to 32 bits. Returns {clipped, value}.
    function automatic logic [DATA_W:0] fixed_dot(int a_base, int a_step,
                                                   int b_base, int b_step, int n);
        logic signed [66:0] acc;
        logic signed [63:0] prod;
        logic signed [66:0] q;
        int k;
        acc = '0;
        for (k = 0; k < n; k++) begin
            prod = $signed(a_mem[a_base + k * a_step]) * $signed(b_mem[b_base + k * b_step]);
            acc  = acc + prod;
        end
        q = acc >>> FRAC_BITS;
        if (q[66:31] != {36{q[66]}})
            return q[66] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
        return {1'b0, q[31:0]};
    endfunction

    // Works out the whole result matrix of one compute word, row-major.
    function automatic void queue_result_matrix();
        int d;
        int i;
        int j;
        logic [DATA_W:0] r;
        result_element_t e;
        d = effective_dim();
        for (i = 0; i < d; i++) begin
            for (j = 0; j < d; j++) begin
                if (mode_reg == MODE_VEC && j > 0)
                    break;
                case (mode_reg)
                    MODE_MUL:    r = fixed_dot(i * d, 1, j, d, d);
                    MODE_MUL_BT: r = fixed_dot(i * d, 1, j * d, 1, d);
                    MODE_VEC:    r = fixed_dot(i * d, 1, 0, 1, d);
                    default:     r = {1'b0, a_mem[j * d + i]};
                endcase
                e.row    = POS_W'(i);
                e.column = POS_W'(j);
                e.value  = r[DATA_W-1:0];
                e.sat    = r[DATA_W];
                e.last   = (i == d - 1) && (mode_reg == MODE_VEC || j == d - 1);
                if (e.sat)
                    saturated_owed++;
                owed_elements.push_back(e);
            end
        end
    endfunction

    // Mostly small Q16.16 values so sums stay in range, plus wide and extreme ones.
    function automatic logic [DATA_W-1:0] rand_q16();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'h0000_0001;
                    4:       return 32'hFFFF_FFFF;
                    default: return 32'h0001_0000;
                endcase
            end
            1:       return v;
            2, 3:    return {{8{v[23]}}, v[23:0]};
            default: return {{14{v[17]}}, v[17:0]};
        endcase
    endfunction

    // Sends one word on s_. Entered and left just after a falling edge; valid
    // stays high into the next word unless a gap is inserted.
    task automatic send_word(action_t act, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_action        = act;
        s_element_index = idx;
        s_element_value = val;
        do @(posedge aclk); while (!s_ready);
        // word taken at this edge: mirror it in the shadow model
        case (act)
            ACT_LOAD_A: begin
                a_mem[idx] = val;
                a_set[idx] = 1'b1;
                words_sent++;
            end
            ACT_LOAD_B: begin
                b_mem[idx] = val;
                b_set[idx] = 1'b1;
                words_sent++;
            end
            ACT_COMPUTE: begin
                queue_result_matrix();
                runs_by_mode[mode_reg]++;
                words_sent++;
            end
            default: ignored_words++;
        endcase
        @(negedge aclk);
    endtask

    // Register write, only once the block has drained everything it owes.
    task automatic write_reg(logic idx, logic [DIM_W-1:0] data);
        s_valid = 1'b0;
        while (owed_elements.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_DIMENSION)
            dim_reg = data;
        else
            mode_reg = mode_t'(data[1:0]);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // upper data bits are don't-care for the mode register, so they get noise
    task automatic set_mode(mode_t m);
        write_reg(CFG_MODE, {2'($urandom_range(0, 3)), m});
    endtask

    task automatic send_compute();
        send_word(ACT_COMPUTE, IDX_W'($urandom()), $urandom());
    endtask

    // Loads the operands the next compute needs. Unwritten entries are always
    // loaded; written ones are refreshed with the given percentage.
    task automatic load_operands(int d, int fresh_pct);
        int idx;
        int b_span;
        case (mode_reg)
            MODE_XPOSE: b_span = 0;
            MODE_VEC:   b_span = d;
            default:    b_span = d * d;
        endcase
        for (idx = 0; idx < d * d; idx++) begin
            if (!a_set[idx] || $urandom_range(0, 99) < fresh_pct)
                send_word(ACT_LOAD_A, IDX_W'(idx), rand_q16());
            if (idx < b_span && (!b_set[idx] || $urandom_range(0, 99) < fresh_pct))
                send_word(ACT_LOAD_B, IDX_W'(idx), rand_q16());
        end
    endtask

    // Reset values: 3x3 product with both saturation directions and plain sums.
    task automatic test_reset_defaults();
        logic [DATA_W-1:0] a_init [9];
        logic [DATA_W-1:0] b_init [9];
        int idx;
        a_init = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        b_init = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0002_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'hFFFF_8000, 32'h0000_8000};
        for (idx = 0; idx < 9; idx++) begin
            send_word(ACT_LOAD_A, IDX_W'(idx), a_init[idx]);
            send_word(ACT_LOAD_B, IDX_W'(idx), b_init[idx]);
        end
        send_compute();
    endtask

    // Dimension 0 behaves as 1; every operation on the single element.
    task automatic test_dimension_floor();
        mode_t all_modes [4];
        int k;
        all_modes = '{MODE_MUL, MODE_MUL_BT, MODE_VEC, MODE_XPOSE};
        write_reg(CFG_DIMENSION, 4'd0);
        for (k = 0; k < 4; k++) begin
            set_mode(all_modes[k]);
            send_compute();
        end
    endtask

    // Action 3 must neither emit nor touch the stores; the transpose after it
    // shows element 0 of A unchanged.
    task automatic test_unused_action();
        send_word(ACT_NONE, 6'h3F, 32'hFFFF_FFFF);
        send_word(ACT_NONE, 6'h00, 32'h8000_0000);
        send_compute();
    endtask

    // Full 8x8 stores, then dimensions above MAX_DIM in the remaining modes.
    task automatic test_dimension_ceiling();
        int idx;
        write_reg(CFG_DIMENSION, 4'd8);
        set_mode(MODE_MUL);
        for (idx = 0; idx < STORE_DEPTH; idx++) begin
            send_word(ACT_LOAD_A, IDX_W'(idx), rand_q16());
            send_word(ACT_LOAD_B, IDX_W'(idx), rand_q16());
        end
        send_compute();
        write_reg(CFG_DIMENSION, 4'd15);
        set_mode(MODE_MUL_BT);
        send_compute();
        write_reg(CFG_DIMENSION, 4'd9);
        set_mode(MODE_VEC);
        send_compute();
        set_mode(MODE_XPOSE);
        send_compute();
    endtask

    // One load-then-compute sequence with random settings and occasional noise.
    task automatic random_run();
        int pick;
        int d;
        if ($urandom_range(0, 99) < 60) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                d = 0;
            else if (pick < 75)
                d = $urandom_range(1, 4);
            else if (pick < 92)
                d = $urandom_range(5, 8);
            else
                d = $urandom_range(9, 15);
            write_reg(CFG_DIMENSION, DIM_W'(d));
        end
        if ($urandom_range(0, 99) < 60)
            set_mode(mode_t'($urandom_range(0, 3)));
        d = effective_dim();
        load_operands(d, $urandom_range(20, 100));
        case ($urandom_range(0, 9))
            0: send_word(ACT_NONE, IDX_W'($urandom()), $urandom());
            1: send_word($urandom_range(0, 1) ? ACT_LOAD_A : ACT_LOAD_B,
                         IDX_W'($urandom()), rand_q16());
            default: ;
        endcase
        send_compute();
        // back-to-back run on the same operands
        if ($urandom_range(0, 4) == 0)
            send_compute();
    endtask

    task automatic test_random_runs();
        while (words_sent < CALM_AFTER)
            random_run();
    endtask

    // tail of the run at full rate on both sides
    task automatic test_full_rate_runs();
        idle_on = 1'b0;
        while (words_sent < WORD_TARGET)
            random_run();
    endtask

    // Result side: random stall bursts while idling is on, else always ready.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_on && aresetn && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // Every accepted result word is matched against the oldest owed element.
    always @(posedge aclk) begin
        result_element_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (owed_elements.size() == 0) begin
                report_mismatch($sformatf("unexpected word row %0d col %0d value %h",
                                          m_result_row, m_result_column, m_result_value));
            end else begin
                want = owed_elements.pop_front();
                if (m_result_row !== want.row || m_result_column !== want.column
                        || m_result_value !== want.value || m_saturated !== want.sat
                        || m_last_result !== want.last)
                    report_mismatch($sformatf(
                        "got r%0d c%0d %h sat %b last %b, want r%0d c%0d %h sat %b last %b",
                        m_result_row, m_result_column, m_result_value, m_saturated,
                        m_last_result, want.row, want.column, want.value, want.sat,
                        want.last));
            end
        end
    end

    initial begin
        s_valid         = 1'b0;
        s_action        = ACT_LOAD_A;
        s_element_index = '0;
        s_element_value = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_DIMENSION;
        cfg_data        = '0;
        aresetn         = 1'b0;
        dim_reg         = 4'd3;
        mode_reg        = MODE_MUL;
        a_set           = '0;
        b_set           = '0;
        idle_on         = 1'b1;
        error_count     = 0;
        words_sent      = 0;
        ignored_words   = 0;
        results_seen    = 0;
        saturated_owed  = 0;
        cycle_count     = 0;
        runs_by_mode    = '{0, 0, 0, 0};

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_dimension_floor();
        test_unused_action();
        test_dimension_ceiling();
        test_random_runs();
        test_full_rate_runs();

        // let the last run drain, then a quiet stretch to catch strays
        s_valid = 1'b0;
        while (owed_elements.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d load/compute words and %0d ignored words, %0d result words",
                 words_sent, ignored_words, results_seen);
        $display("compute runs A*B %0d, A*B^T %0d, A*v %0d, A^T %0d; %0d clipped elements",
                 runs_by_mode[0], runs_by_mode[1], runs_by_mode[2], runs_by_mode[3],
                 saturated_owed);
        if (error_count == 0)
            $display("square_matrix_multiply_engine_tb OK");
        else
            $display("square_matrix_multiply_engine_tb NOT OK");
        $finish;
    end

endmodule

/* files.f */
sv/smm_pkg.sv
sv/smm_mac.sv
sv/square_matrix_multiply_engine.sv
dv/square_matrix_multiply_engine_tb.sv
